// ----- src/ac_pkg.sv -----
// ----------------------------------------------------------------------------
// ac_pkg: amount codec shared definitions
// Widths, divider geometry, controller states, datapath operations and the
// status group passed between controller and datapath.
// ----------------------------------------------------------------------------
package ac_pkg;

  localparam int unsigned VAL_W     = 64;
  localparam int unsigned DIGIT_W   = 4;
  // constant divider: four shift-add stages, a final shift, one correction
  localparam int unsigned DIV_STEPS = 6;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [DIGIT_W-1:0] MAX_EXP  = 4'd9;
  localparam logic [DIGIT_W-1:0] DIV_TEN  = 4'd10;
  localparam logic [DIGIT_W-1:0] DIV_NINE = 4'd9;

  // largest value that can be scaled by ten without leaving 64 bits
  localparam logic [VAL_W-1:0] MUL10_LIMIT = 64'hFFFF_FFFF_FFFF_FFFF / 64'd10;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,       // n <= value, e <= 0, ovf <= 0
    OP_DIV10,      // q <= first estimate of n / 10, r <= 0
    OP_DIV9,       // q <= first estimate of n / 9, r <= 0
    OP_DIV_STEP,   // one divider stage
    OP_STRIP,      // n <= q, e <= e + 1
    OP_TAKE_E,     // e <= r, n <= q
    OP_Q_MUL9,     // n <= q * 9
    OP_Q_MUL10,    // n <= q * 10
    OP_ADD_RM1,    // n <= n + r - 1
    OP_ADD_RP1,    // n <= n + r + 1
    OP_N_DEC,      // n <= n - 1
    OP_N_INC,      // n <= n + 1
    OP_N_MUL10,    // n <= n * 10
    OP_ADD_E1,     // n <= n + e + 1
    OP_SCALE,      // ovf check, n <= n * 10, e <= e - 1
    OP_OUT_LOAD    // result register <= n, ovf
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_C_START,
    ST_C_DIV,
    ST_C_TEST,
    ST_C_ECHK,
    ST_C_ADD_D,
    ST_C_E9_DEC,
    ST_C_MUL10,
    ST_C_ADD_E,
    ST_D_DEC,
    ST_D_START,
    ST_D_DIV10,
    ST_D_TAKE_E,
    ST_D_BRANCH,
    ST_D_DIV9,
    ST_D_MUL10,
    ST_D_ADD_D,
    ST_D_SCALE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic rem_zero;
    logic n_zero;
    logic e_is_max;
    logic e_zero;
  } status_t;

endpackage

// ----- src/amount_codec.sv -----
// ----------------------------------------------------------------------------
// amount_codec: 64-bit amount compression / decompression
// From accept to result valid, zero takes a short path; compress time grows
//   with each trailing zero stripped, up to nine of them.
// Decompress time grows with each power of ten in the exponent; exponent
//   nine skips the division by nine.
// Throughput: one item at a time; the next item is taken the cycle after the
//   result moves into the output register, which waits while one is held.
// Reset clears the controller and valid.
// ----------------------------------------------------------------------------
module amount_codec (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     action_i,
  input  logic [ac_pkg::VAL_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [ac_pkg::VAL_W-1:0] result_o,
  output logic                     overflow_o
);
  import ac_pkg::*;

  // Compress: strip trailing zeros by repeated division by ten, stopping at
  // a nonzero remainder (that remainder is the last digit) or at exponent
  // nine, then build the code with shift-add arithmetic.
  // Decompress: subtract one, divide by ten for the exponent, divide by nine
  // for the last digit unless the exponent is nine, then scale by ten once per
  // exponent step with a sticky overflow flag.
  // Each division is a shift-add reciprocal estimate followed by a single
  // remainder correction.
  cmd_t    cmd;
  status_t status;

  ac_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // the result register holds a finished item while the next is worked on
  ac_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .value_i    (value_i),
    .status_o   (status),
    .result_o   (result_o),
    .overflow_o (overflow_o)
  );

endmodule

// ----- src/ac_datapath.sv -----
// ----------------------------------------------------------------------------
// ac_datapath: amount codec datapath
// Value and quotient registers, a shift-add reciprocal divider (by 9 or 10),
// shift-add scaling by ten and the result register.
// ----------------------------------------------------------------------------
module ac_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ac_pkg::cmd_t               cmd_i,
  input  logic [ac_pkg::VAL_W-1:0]   value_i,
  output ac_pkg::status_t            status_o,
  output logic [ac_pkg::VAL_W-1:0]   result_o,
  output logic                       overflow_o
);
  import ac_pkg::*;

  logic [VAL_W-1:0]     n_q, n_d;
  logic [VAL_W-1:0]     q_q, q_d;
  logic [DIGIT_W-1:0]   r_q, r_d;
  logic [DIGIT_W-1:0]   e_q, e_d;
  logic [DIGIT_W-1:0]   div_q, div_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 ovf_q, ovf_d;
  logic [VAL_W-1:0]     res_q, res_d;
  logic                 res_ovf_q, res_ovf_d;

  logic [VAL_W-1:0]     q_step;
  logic [DIGIT_W-1:0]   r_step;
  logic [DIGIT_W:0]     dq_lo;
  logic [DIGIT_W:0]     rem_est;

  // The estimate only ever falls short, by at most one, so the remainder
  // left by it is below twice the divisor and its low five bits suffice.
  assign dq_lo   = (div_q == DIV_NINE) ?
                   ((q_q[DIGIT_W:0] << 3) + q_q[DIGIT_W:0]) :
                   ((q_q[DIGIT_W:0] << 3) + (q_q[DIGIT_W:0] << 1));
  assign rem_est = n_q[DIGIT_W:0] - dq_lo;

  // reciprocal series: 0.8 or 8/9 built up in q, then divided by eight
  always_comb begin
    q_step = q_q;
    r_step = r_q;
    unique case (cnt_q)
      DIV_CNT_W'(0): q_step = q_q + ((div_q == DIV_NINE) ? (q_q >> 6) : (q_q >> 4));
      DIV_CNT_W'(1): q_step = q_q + ((div_q == DIV_NINE) ? (q_q >> 12) : (q_q >> 8));
      DIV_CNT_W'(2): q_step = q_q + ((div_q == DIV_NINE) ? (q_q >> 24) : (q_q >> 16));
      DIV_CNT_W'(3): q_step = q_q + ((div_q == DIV_NINE) ? (q_q >> 48) : (q_q >> 32));
      DIV_CNT_W'(4): q_step = q_q >> 3;
      default: begin
        if (rem_est >= {1'b0, div_q}) begin
          q_step = q_q + VAL_W'(1);
          r_step = DIGIT_W'(rem_est - {1'b0, div_q});
        end else begin
          r_step = rem_est[DIGIT_W-1:0];
        end
      end
    endcase
  end

  always_comb begin
    n_d       = n_q;
    q_d       = q_q;
    r_d       = r_q;
    e_d       = e_q;
    div_d     = div_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    res_d     = res_q;
    res_ovf_d = res_ovf_q;
    unique case (cmd_i.op)
      OP_NONE: ;
      OP_LOAD: begin
        n_d   = value_i;
        e_d   = '0;
        ovf_d = 1'b0;
      end
      OP_DIV10, OP_DIV9: begin
        r_d   = '0;
        cnt_d = '0;
        if (cmd_i.op == OP_DIV9) begin
          div_d = DIV_NINE;
          q_d   = (n_q >> 1) + (n_q >> 2) + (n_q >> 3);
        end else begin
          div_d = DIV_TEN;
          q_d   = (n_q >> 1) + (n_q >> 2);
        end
      end
      OP_DIV_STEP: begin
        q_d   = q_step;
        r_d   = r_step;
        cnt_d = cnt_q + DIV_CNT_W'(1);
      end
      OP_STRIP: begin
        n_d = q_q;
        e_d = e_q + DIGIT_W'(1);
      end
      OP_TAKE_E: begin
        n_d = q_q;
        e_d = r_q;
      end
      OP_Q_MUL9:   n_d = (q_q << 3) + q_q;
      OP_Q_MUL10:  n_d = (q_q << 3) + (q_q << 1);
      OP_ADD_RM1:  n_d = n_q + VAL_W'(r_q) - VAL_W'(1);
      OP_ADD_RP1:  n_d = n_q + VAL_W'(r_q) + VAL_W'(1);
      OP_N_DEC:    n_d = n_q - VAL_W'(1);
      OP_N_INC:    n_d = n_q + VAL_W'(1);
      OP_N_MUL10:  n_d = (n_q << 3) + (n_q << 1);
      OP_ADD_E1:   n_d = n_q + VAL_W'(e_q) + VAL_W'(1);
      OP_SCALE: begin
        if (n_q > MUL10_LIMIT) begin
          ovf_d = 1'b1;
        end
        n_d = (n_q << 3) + (n_q << 1);
        e_d = e_q - DIGIT_W'(1);
      end
      OP_OUT_LOAD: begin
        res_d     = n_q;
        res_ovf_d = ovf_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q   <= '0;
      e_q   <= '0;
      div_q <= DIV_TEN;
      cnt_q <= '0;
    end else begin
      r_q   <= r_d;
      e_q   <= e_d;
      div_q <= div_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    q_q       <= q_d;
    ovf_q     <= ovf_d;
    res_q     <= res_d;
    res_ovf_q <= res_ovf_d;
  end

  assign status_o.div_last = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
  assign status_o.rem_zero = (r_q == '0);
  assign status_o.n_zero   = (n_q == '0);
  assign status_o.e_is_max = (e_q == MAX_EXP);
  assign status_o.e_zero   = (e_q == '0);

  assign result_o   = res_q;
  assign overflow_o = res_ovf_q;

  // exponent never passes nine
  a_e_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_q <= MAX_EXP)
    else $error("exponent out of range");

  // divider remainder stays below the divisor
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_q < div_q)
    else $error("remainder not below divisor");

endmodule

// ----- src/ac_controller.sv -----
// ----------------------------------------------------------------------------
// ac_controller: amount codec sequencer
// Handshakes both channels and steps the datapath through compress or
// decompress.
// ----------------------------------------------------------------------------
module ac_controller (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            action_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  ac_pkg::status_t status_i,
  output ac_pkg::cmd_t    cmd_o
);
  import ac_pkg::*;

  state_e state_q, state_d;
  logic   act_q, act_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    act_d   = act_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CHECK;
          act_d   = action_i;
        end
      end
      ST_CHECK: begin
        priority if (status_i.n_zero) state_d = ST_FINISH;
        else if (act_q)               state_d = ST_D_DEC;
        else                          state_d = ST_C_START;
      end
      ST_C_START:  state_d = ST_C_DIV;
      ST_C_DIV:    if (status_i.div_last) state_d = ST_C_TEST;
      ST_C_TEST:   state_d = status_i.rem_zero ? ST_C_ECHK : ST_C_ADD_D;
      ST_C_ECHK:   state_d = status_i.e_is_max ? ST_C_E9_DEC : ST_C_START;
      ST_C_ADD_D:  state_d = ST_C_MUL10;
      ST_C_E9_DEC: state_d = ST_C_MUL10;
      ST_C_MUL10:  state_d = ST_C_ADD_E;
      ST_C_ADD_E:  state_d = ST_FINISH;
      ST_D_DEC:    state_d = ST_D_START;
      ST_D_START:  state_d = ST_D_DIV10;
      ST_D_DIV10:  if (status_i.div_last) state_d = ST_D_TAKE_E;
      ST_D_TAKE_E: state_d = ST_D_BRANCH;
      ST_D_BRANCH: state_d = status_i.e_is_max ? ST_D_SCALE : ST_D_DIV9;
      ST_D_DIV9:   if (status_i.div_last) state_d = ST_D_MUL10;
      ST_D_MUL10:  state_d = ST_D_ADD_D;
      ST_D_ADD_D:  state_d = ST_D_SCALE;
      ST_D_SCALE:  if (status_i.e_zero) state_d = ST_FINISH;
      ST_FINISH:   if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.op    = OP_NONE;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE:     if (in_valid_i) cmd_o.op = OP_LOAD;
      ST_CHECK:    ;
      ST_C_START:  cmd_o.op = OP_DIV10;
      ST_C_DIV:    cmd_o.op = OP_DIV_STEP;
      ST_C_TEST:   cmd_o.op = status_i.rem_zero ? OP_STRIP : OP_Q_MUL9;
      ST_C_ECHK:   ;
      ST_C_ADD_D:  cmd_o.op = OP_ADD_RM1;
      ST_C_E9_DEC: cmd_o.op = OP_N_DEC;
      ST_C_MUL10:  cmd_o.op = OP_N_MUL10;
      ST_C_ADD_E:  cmd_o.op = OP_ADD_E1;
      ST_D_DEC:    cmd_o.op = OP_N_DEC;
      ST_D_START:  cmd_o.op = OP_DIV10;
      ST_D_DIV10:  cmd_o.op = OP_DIV_STEP;
      ST_D_TAKE_E: cmd_o.op = OP_TAKE_E;
      ST_D_BRANCH: cmd_o.op = status_i.e_is_max ? OP_N_INC : OP_DIV9;
      ST_D_DIV9:   cmd_o.op = OP_DIV_STEP;
      ST_D_MUL10:  cmd_o.op = OP_Q_MUL10;
      ST_D_ADD_D:  cmd_o.op = OP_ADD_RP1;
      ST_D_SCALE:  if (!status_i.e_zero) cmd_o.op = OP_SCALE;
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.op    = OP_OUT_LOAD;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      act_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      act_q       <= act_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // an accepted item closes the input until it is finished
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while busy");

  // loading the result register always raises valid
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == OP_OUT_LOAD |=> out_valid_o)
    else $error("result loaded without valid");

  // result register only overwritten once the previous item has left
  a_no_clobber: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == OP_OUT_LOAD |-> !out_valid_q || out_ready_i)
    else $error("pending result overwritten");

endmodule

// ----- verif/tb_amount_codec.sv -----
// ----------------------------------------------------------------------------
// tb_amount_codec: self-checking testbench for the amount codec
// Drives amounts and codes through the valid/ready input channel, predicts
// each compressed code or decompressed amount (with its overflow flag) and
// checks every output item in order. The sender works in bursts with random
// gaps, the receiver stalls on a drifting pattern of its own, and the sender
// holds off until the pipe has drained at a few points.
// ----------------------------------------------------------------------------
module tb_amount_codec;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [ac_pkg::VAL_W-1:0] amount_t;

  // action codes on action_i
  localparam logic ACT_COMPRESS   = 1'b0;
  localparam logic ACT_DECOMPRESS = 1'b1;

  localparam int unsigned RAND_ITEMS   = 1530;
  // cycles with no item moving on either channel before the run is abandoned;
  // sized to cover the worst item plus a receiver stall plus a sender gap
  localparam int unsigned STALL_LIMIT  = 20000;
  // quiet spell at the end, once every expected result has come back
  localparam int unsigned DRAIN_CYCLES = 250;

  // ----------------------------------------------------------------------------
  // Expected-result store and codec predictor
  // ----------------------------------------------------------------------------
  typedef struct {
    amount_t result;
    logic    overflow;
  } codec_out_t;

  class amount_scoreboard;
    codec_out_t pending_q[$];
    int unsigned failures;

    // largest amount that can be scaled by ten and still fit in 64 bits
    static function amount_t scale_limit();
      return 64'hFFFF_FFFF_FFFF_FFFF / 64'd10;
    endfunction

    // amount -> code; wraps modulo 2^64 for large amounts
    static function amount_t pack_amount(amount_t amt);
      amount_t n;
      amount_t d;
      int unsigned e;
      if (amt == 0) return '0;
      n = amt;
      e = 0;
      while (e < 9 && (n % 10) == 0) begin
        n = n / 10;
        e++;
      end
      if (e < 9) begin
        d = n % 10;
        n = n / 10;
        return 1 + (n * 9 + d - 1) * 10 + e;
      end
      return 1 + (n - 1) * 10 + 9;
    endfunction

    // code -> amount; the flag is sticky over the scaling steps
    static function amount_t unpack_code(amount_t code, output logic ovf);
      amount_t x;
      amount_t n;
      int unsigned e;
      ovf = 1'b0;
      if (code == 0) return '0;
      x = code - 1;
      e = 32'(x % 10);
      x = x / 10;
      if (e < 9) n = (x / 9) * 10 + (x % 9) + 1;
      else       n = x + 1;
      for (int unsigned i = 0; i < e; i++) begin
        if (n > scale_limit()) ovf = 1'b1;
        n = n * 10;
      end
      return n;
    endfunction

    function void note_item(logic act, amount_t value);
      codec_out_t exp_out;
      if (act == ACT_COMPRESS) begin
        exp_out.result   = pack_amount(value);
        exp_out.overflow = 1'b0;
      end else begin
        exp_out.result = unpack_code(value, exp_out.overflow);
      end
      pending_q.push_back(exp_out);
    endfunction

    function void check_result(amount_t result, logic overflow);
      codec_out_t exp_out;
      if (pending_q.size() == 0) begin
        $error("result item with nothing expected: result %h overflow %b", result, overflow);
        failures++;
        return;
      end
      exp_out = pending_q.pop_front();
      if (result !== exp_out.result) begin
        $error("result: expected %h, got %h", exp_out.result, result);
        failures++;
      end
      if (overflow !== exp_out.overflow) begin
        $error("overflow: expected %b, got %b", exp_out.overflow, overflow);
        failures++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_q.size();
    endfunction
  endclass

  // ----------------------------------------------------------------------------
  // Clock, reset and DUT
  // ----------------------------------------------------------------------------
  logic    clk_i;
  logic    rst_ni;
  logic    in_valid;
  logic    in_ready;
  logic    action;
  amount_t value;
  logic    out_valid;
  logic    out_ready;
  amount_t result;
  logic    overflow;

  amount_scoreboard sb = new();

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  amount_codec u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .action_i    (action),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .result_o    (result),
    .overflow_o  (overflow)
  );

  // ----------------------------------------------------------------------------
  // Monitors: both channels are sampled at the rising edge, where everything
  // the TB drives has been stable since the falling edge.
  // ----------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && in_ready) sb.note_item(action, value);
    if (rst_ni && out_valid && out_ready) sb.check_result(result, overflow);
  end

  // Watchdog: counts cycles in which no item moves on either side
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("amount_codec regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ----------------------------------------------------------------------------
  // Receiver: a stall mode is held for a random spell, then another is drawn.
  // Modes: always ready, mostly ready, mostly stalled, on/off blocks set by bit four of the spell counter.
  // ----------------------------------------------------------------------------
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(40, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= stall_left[4];
    endcase
  end

  // ----------------------------------------------------------------------------
  // Sender
  // ----------------------------------------------------------------------------
  int unsigned burst_left = 0;

  function automatic amount_t rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic amount_t pow10(int unsigned k);
    amount_t p;
    p = 1;
    repeat (k) p = p * 10;
    return p;
  endfunction

  // amounts skewed towards trailing zeros, extremes and small values
  function automatic amount_t pick_amount();
    case ($urandom_range(0, 5))
      0: return rand64();
      1: return rand64() >> $urandom_range(1, 63);
      2: return $urandom_range(1, 99999) * pow10($urandom_range(0, 12));
      3: return (rand64() >> $urandom_range(34, 63)) * pow10($urandom_range(0, 14));
      4: return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 1000);
      default: return amount_t'($urandom_range(0, 20));
    endcase
  endfunction

  // codes: well-formed ones from real amounts, every exponent, and noise
  function automatic amount_t pick_code();
    case ($urandom_range(0, 5))
      0: return rand64();
      1: return amount_t'($urandom_range(0, 2000));
      2, 3: return amount_scoreboard::pack_amount(pick_amount());
      4: return (rand64() >> $urandom_range(4, 60)) * 10 + $urandom_range(1, 10);
      default: return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 1000);
    endcase
  endfunction

  // Presents one item from a falling edge and returns at the falling edge
  // after it was taken, leaving valid high for a back-to-back item.
  task automatic send_item(logic act, amount_t v);
    in_valid <= 1'b1;
    action   <= act;
    value    <= v;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Burst pacing: at the end of a burst valid drops for a random gap,
  // mostly short, sometimes long enough to span a whole item.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 10);
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 220) : $urandom_range(0, 6);
    if (gap == 0) return;
    in_valid <= 1'b0;
    repeat (gap) @(negedge clk_i);
  endtask

  // hold off until every expected result has come back
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_directed();
    amount_t top_code;
    top_code = amount_scoreboard::pack_amount(64'hFFFF_FFFF_FFFF_FFFF);
    // compress: zero, single digits, full nine-zero strip, wrap-around codes
    send_item(ACT_COMPRESS, 64'd0);
    send_item(ACT_COMPRESS, 64'd1);
    send_item(ACT_COMPRESS, 64'd9);
    send_item(ACT_COMPRESS, 64'd10);
    send_item(ACT_COMPRESS, 64'd123456789);
    send_item(ACT_COMPRESS, 64'd1000000000);
    send_item(ACT_COMPRESS, 64'd5000000000);
    send_item(ACT_COMPRESS, 64'd10000000000);
    send_item(ACT_COMPRESS, 64'd10000000000000000000);
    send_item(ACT_COMPRESS, 64'd18446744073709551610);
    send_item(ACT_COMPRESS, 64'h8000_0000_0000_0000);
    send_item(ACT_COMPRESS, 64'hFFFF_FFFF_FFFF_FFFF);
    // decompress: zero, smallest codes, e = 9 and e = 8, the largest amount,
    // one step past it, and the all-ones code
    send_item(ACT_DECOMPRESS, 64'd0);
    send_item(ACT_DECOMPRESS, 64'd1);
    send_item(ACT_DECOMPRESS, 64'd2);
    send_item(ACT_DECOMPRESS, 64'd9);
    send_item(ACT_DECOMPRESS, 64'd10);
    send_item(ACT_DECOMPRESS, top_code);
    send_item(ACT_DECOMPRESS, top_code + 10);
    send_item(ACT_DECOMPRESS, 64'h1000_0000_0000_0000);
    send_item(ACT_DECOMPRESS, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(ACT_DECOMPRESS, 64'hFFFF_FFFF_FFFF_FFF6);
  endtask

  // ----------------------------------------------------------------------------
  // Main sequence
  // ----------------------------------------------------------------------------
  initial begin
    logic    act;
    amount_t v;
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    action    = ACT_COMPRESS;
    value     = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_directed();
    hold_until_drained();

    for (int unsigned i = 0; i < RAND_ITEMS; i++) begin
      act = ($urandom_range(0, 1) == 0) ? ACT_COMPRESS : ACT_DECOMPRESS;
      v   = (act == ACT_COMPRESS) ? pick_amount() : pick_code();
      send_item(act, v);
      if ($urandom_range(0, 199) == 0) hold_until_drained();
      else pace_sender();
    end

    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("amount_codec regression: pass");
    end else begin
      $display("amount_codec regression: fail");
    end
    $finish;
  end

endmodule
